[src/spso_pkg.sv]
`default_nettype none

package spso_pkg;

  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned MULT_W     = 3;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_W      = SAMPLE_W - 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = PHASE_W'(39370534);
  localparam logic [AMP_W-1:0]   AMPLITUDE_RST  = AMP_W'(16384);

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] MAG_MAX     = 64'd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_AMPLITUDE  = 2'd1
  } cfg_reg_t;

  // quarter-wave entry k, sampled at the middle of its cell
  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned abits);
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] v;
    t  = 64'(2 * k + 1) << (29 - abits);
    x  = (HALF_PI_Q30 * t) >> 30;
    x2 = (x * x) >> 30;
    r  = Q30_ONE - x2 / 64'd110;
    r  = Q30_ONE - ((x2 * r) >> 30) / 64'd72;
    r  = Q30_ONE - ((x2 * r) >> 30) / 64'd42;
    r  = Q30_ONE - ((x2 * r) >> 30) / 64'd20;
    r  = Q30_ONE - ((x2 * r) >> 30) / 64'd6;
    v  = (x * r) >> 30;
    v  = (v * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > MAG_MAX) begin
      v = MAG_MAX;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

[src/spso_if.sv]
`default_nettype none

interface spso_in_if;
  logic                            valid;
  logic                            ready;
  logic [spso_pkg::MULT_W-1:0]     pitch_multiple;

  modport source (output valid, output pitch_multiple, input ready);
  modport sink   (input valid, input pitch_multiple, output ready);
endinterface

interface spso_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [spso_pkg::SAMPLE_W-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface spso_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [spso_pkg::CFG_IDX_W-1:0]    idx;
  logic [spso_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

[src/stepped_pitch_sine_oscillator.sv]
`default_nettype none
// channel   | role        | payload
// in_chan   | frame tick  | pitch_multiple (3 bit unsigned)
// out_chan  | sine sample | sample (16 bit signed Q1.15)
// cfg_chan  | reg write   | idx (0 phase_step, 1 amplitude), data
// Three register stages: sine ROM read, gain multiply, sign and output register.
// The input transfer loads the ROM read register; the gain multiply and sign
// registers follow before the sample is valid. One frame per cycle sustained
// while the sink is ready; the phase add and ROM port each take one frame a cycle.
// Synchronous active-low reset clears phase and stage valids and restores the
// register reset values.
// Each stage holds while the one after it is full and stalled.
module stepped_pitch_sine_oscillator #(
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  spso_in_if.sink     in_chan,
  spso_out_if.source  out_chan,
  spso_cfg_if.sink    cfg_chan
);

  localparam int unsigned TAB_SIZE = 1 << TABLE_ADDR_BITS;
  localparam int unsigned PW       = spso_pkg::PHASE_W;
  localparam int unsigned MW       = spso_pkg::MAG_W;
  localparam int unsigned AW       = spso_pkg::AMP_W;
  localparam int unsigned PROD_W   = MW + AW;

  logic [MW-1:0] sine_rom [TAB_SIZE];

  for (genvar k = 0; k < TAB_SIZE; k++) begin : g_rom
    assign sine_rom[k] = spso_pkg::sine_entry(k, TABLE_ADDR_BITS);
  end

  logic [PW-1:0] phase_step_r;
  logic [AW-1:0] amplitude_r;
  logic [PW-1:0] phase_r;

  logic                        v1_r;
  logic [MW-1:0]               rom_q_r;
  logic                        neg1_r;
  logic                        v2_r;
  logic [MW-1:0]               mag2_r;
  logic                        neg2_r;
  logic                        out_v_r;
  logic signed [spso_pkg::SAMPLE_W-1:0] sample_r;

  logic                        rdy1;
  logic                        rdy2;
  logic                        rdy3;
  logic                        in_fire;
  logic [TABLE_ADDR_BITS-1:0]  rom_addr;
  logic [PW-1:0]               phase_nxt;
  logic [PROD_W-1:0]           scaled;
  logic [spso_pkg::SAMPLE_W-1:0] mag_ext;

  assign rdy3    = !out_v_r || out_chan.ready;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign in_fire = in_chan.valid && rdy1;

  assign in_chan.ready  = rdy1;
  assign out_chan.valid = out_v_r;
  assign out_chan.sample = sample_r;
  assign cfg_chan.ready = 1'b1;

  // mirror the cell in odd quadrants
  assign rom_addr  = phase_r[PW-3 -: TABLE_ADDR_BITS]
                     ^ {TABLE_ADDR_BITS{phase_r[PW-2]}};
  assign phase_nxt = phase_r + PW'(in_chan.pitch_multiple * phase_step_r);
  assign scaled    = PROD_W'(rom_q_r) * PROD_W'(amplitude_r)
                     + PROD_W'(1 << (AW - 1));
  assign mag_ext   = {1'b0, mag2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= spso_pkg::PHASE_STEP_RST;
      amplitude_r  <= spso_pkg::AMPLITUDE_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.idx)
        spso_pkg::CFG_PHASE_STEP: phase_step_r <= cfg_chan.data[PW-1:0];
        spso_pkg::CFG_AMPLITUDE:  amplitude_r  <= cfg_chan.data[AW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
      end
      if (rdy1) begin
        v1_r <= in_chan.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        out_v_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rom_q_r <= sine_rom[rom_addr];
      neg1_r  <= phase_r[PW-1];
    end
    if (rdy2 && v1_r) begin
      mag2_r <= scaled[PROD_W-1 -: MW];
      neg2_r <= neg1_r;
    end
    if (rdy3 && v2_r) begin
      sample_r <= neg2_r ? -$signed(mag_ext) : $signed(mag_ext);
    end
  end

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (sample_r <= 16'sd32766) && (sample_r >= -16'sd32766))
    else $error("sample outside symmetric range");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_v_r && !v1_r && !v2_r)
    else $error("pipeline not empty after reset");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(phase_r))
    else $error("phase moved without a transfer");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !rdy2 |=> v1_r && $stable(rom_q_r) && $stable(neg1_r))
    else $error("stalled table read lost");

endmodule

`default_nettype wire

[verif/tb_stepped_pitch_sine_oscillator.sv]
`timescale 1ns / 1ps

class sine_scoreboard;
  logic [spso_pkg::MAG_W-1:0]           quarter_wave[];
  logic [spso_pkg::PHASE_W-1:0]         step;
  logic [spso_pkg::PHASE_W-1:0]         phase;
  logic [spso_pkg::AMP_W-1:0]           gain;
  logic signed [spso_pkg::SAMPLE_W-1:0] expected_samples[$];
  int unsigned                          abits;
  int                                   errors;

  function new(input int unsigned table_bits);
    longint unsigned t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned v;
    abits = table_bits;
    quarter_wave = new[1 << table_bits];
    for (int k = 0; k < (1 << table_bits); k++) begin
      t  = longint'(2 * k + 1) << (29 - table_bits);
      x  = (spso_pkg::HALF_PI_Q30 * t) >> 30;
      x2 = (x * x) >> 30;
      r  = spso_pkg::Q30_ONE - x2 / 110;
      r  = spso_pkg::Q30_ONE - ((x2 * r) >> 30) / 72;
      r  = spso_pkg::Q30_ONE - ((x2 * r) >> 30) / 42;
      r  = spso_pkg::Q30_ONE - ((x2 * r) >> 30) / 20;
      r  = spso_pkg::Q30_ONE - ((x2 * r) >> 30) / 6;
      v  = (x * r) >> 30;
      v  = (v * 32767 + (64'd1 << 29)) >> 30;
      if (v > spso_pkg::MAG_MAX) begin
        v = spso_pkg::MAG_MAX;
      end
      quarter_wave[k] = v[spso_pkg::MAG_W-1:0];
    end
    step   = spso_pkg::PHASE_STEP_RST;
    gain   = spso_pkg::AMPLITUDE_RST;
    phase  = '0;
    errors = 0;
  endfunction

  function void write_reg(input logic [spso_pkg::CFG_IDX_W-1:0] idx,
                          input logic [spso_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      spso_pkg::CFG_PHASE_STEP: begin
        step = data[spso_pkg::PHASE_W-1:0];
      end
      spso_pkg::CFG_AMPLITUDE: begin
        gain = data[spso_pkg::AMP_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // emit the sine of the current phase, then advance the phase
  function void note_tick(input logic [spso_pkg::MULT_W-1:0] mult);
    logic [1:0]                           quad;
    int unsigned                          tab_idx;
    longint unsigned                      mag;
    logic signed [spso_pkg::SAMPLE_W-1:0] mag16;
    quad = phase[spso_pkg::PHASE_W-1:spso_pkg::PHASE_W-2];
    tab_idx = (phase >> (30 - abits)) & ((1 << abits) - 1);
    if (quad[0]) begin
      tab_idx = ((1 << abits) - 1) - tab_idx;
    end
    mag = (longint'(quarter_wave[tab_idx]) * gain + 16384) >> 15;
    mag16 = mag[spso_pkg::SAMPLE_W-1:0];
    expected_samples.push_back(quad[1] ? -mag16 : mag16);
    phase = phase + mult * step;
  endfunction

  function void check_sample(input logic signed [spso_pkg::SAMPLE_W-1:0] actual);
    logic signed [spso_pkg::SAMPLE_W-1:0] want;
    if (expected_samples.size() == 0) begin
      $display("%0t: unexpected sample, expected none, actual %0d", $time, actual);
      errors++;
    end else begin
      want = expected_samples.pop_front();
      if (want !== actual) begin
        $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, actual);
        errors++;
      end
    end
  endfunction

  function int pending();
    return expected_samples.size();
  endfunction
endclass

module tb_stepped_pitch_sine_oscillator;

  localparam int unsigned TAB_BITS = 10;
  localparam logic [spso_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [spso_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic clk;
  logic rst_n;
  int   source_gap_pct = 0;
  int   sink_stall_pct = 0;

  sine_scoreboard osc_sb;

  spso_in_if  in_chan ();
  spso_out_if out_chan ();
  spso_cfg_if cfg_chan ();

  stepped_pitch_sine_oscillator #(
    .TABLE_ADDR_BITS(TAB_BITS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      osc_sb.check_sample(out_chan.sample);
    end
  end

  task automatic send_tick(input logic [spso_pkg::MULT_W-1:0] mult);
    @(negedge clk);
    while ($urandom_range(99) < source_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.pitch_multiple <= mult;
    @(posedge clk);
    while (!in_chan.ready) begin
      @(posedge clk);
    end
    osc_sb.note_tick(mult);
  endtask

  // drop valid, hold until every sample is back, let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (osc_sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [spso_pkg::CFG_IDX_W-1:0] idx,
                           input logic [spso_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.idx   <= idx;
    cfg_chan.data  <= data;
    @(posedge clk);
    while (!cfg_chan.ready) begin
      @(posedge clk);
    end
    osc_sb.write_reg(idx, data);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic reconfigure();
    logic [spso_pkg::CFG_DATA_W-1:0] step_val;
    logic [spso_pkg::CFG_DATA_W-1:0] amp_val;
    case ($urandom_range(3))
      0: step_val = '0;
      1: step_val = '1;
      default: step_val = $urandom;
    endcase
    case ($urandom_range(3))
      0: amp_val = '0;
      1: amp_val = 32'h7FFF;
      default: amp_val = $urandom_range(32767);
    endcase
    amp_val = amp_val | ($urandom & 32'hFFFF_8000);
    cfg_write(spso_pkg::CFG_PHASE_STEP, step_val);
    cfg_write(spso_pkg::CFG_AMPLITUDE, amp_val);
    if ($urandom_range(2) == 0) begin
      cfg_write($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    end
  endtask

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    osc_sb = new(TAB_BITS);
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.pitch_multiple = '0;
    out_chan.ready         = 1'b0;
    cfg_chan.valid         = 1'b0;
    cfg_chan.idx           = spso_pkg::CFG_PHASE_STEP;
    cfg_chan.data          = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // phase zero first, then every multiple at the reset settings
    for (int m = 0; m < 8; m++) begin
      send_tick(spso_pkg::MULT_W'(m));
    end

    // quadrant boundaries at full gain, wrap with multiple seven
    settle();
    cfg_write(spso_pkg::CFG_AMPLITUDE, 32'hFFFF_FFFF);
    cfg_write(spso_pkg::CFG_PHASE_STEP, 32'h4000_0000);
    for (int m = 0; m < 4; m++) begin
      send_tick(3'd1);
    end
    send_tick(3'd7);

    // largest step with zero gain
    settle();
    cfg_write(spso_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF);
    cfg_write(spso_pkg::CFG_AMPLITUDE, 32'h0);
    send_tick(3'd7);
    send_tick(3'd6);

    // spare indices must not disturb the registers
    settle();
    cfg_write(REG_SPARE_A, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_B, 32'h0);
    send_tick(3'd3);
    settle();
    cfg_write(spso_pkg::CFG_PHASE_STEP, 32'h0);
    cfg_write(spso_pkg::CFG_AMPLITUDE, 32'h1);
    send_tick(3'd4);
    send_tick(3'd0);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          source_gap_pct = 24;
          sink_stall_pct = 46;
        end
        1: begin
          source_gap_pct = 46;
          sink_stall_pct = 24;
        end
        default: begin
          source_gap_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        settle();
        reconfigure();
        for (int n = 0; n < 100; n++) begin
          send_tick(spso_pkg::MULT_W'(($urandom_range(4) == 0) ?
                                      $urandom_range(7) : $urandom_range(4)));
          if ($urandom_range(59) == 0) begin
            settle();
          end
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (osc_sb.errors == 0 && osc_sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
